### hw/rtl/ffba_pkg.sv
// Shared types and codes for the first-fit block allocator.
`timescale 1ns / 1ps
`default_nettype none

package ffba_pkg;

  localparam int REQ_W = 21;
  localparam int OFF_W = 20;
  localparam int CNT_W = 21;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOFIT   = 3'd2,
    ST_RANGE   = 3'd3,
    ST_DOUBLE  = 3'd4,
    ST_NOSTART = 3'd5
  } status_e;

  typedef struct packed {
    logic             op;
    logic [REQ_W-1:0] request_bytes;
    logic [OFF_W-1:0] release_offset;
  } req_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [OFF_W-1:0] payload_offset;
    logic [CNT_W-1:0] free_bytes;
    logic [CNT_W-1:0] used_bytes;
  } rsp_t;

endpackage

`default_nettype wire

### hw/rtl/first_fit_block_allocator.sv
// First-fit heap allocator with coalescing: sequencer over one block-table memory.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+--------------------------------
//   in      | to block  | in_valid_i / in_stall_o   | ffba_pkg::req_t  (op, size, off)
//   out     | from block| out_valid_o / out_stall_i | ffba_pkg::rsp_t  (status, off, totals)
//
// Sequencing: one transaction at a time, from acceptance to the result register.
// Allocate: round the size up to the granule (reciprocal multiply, then multiply
// back), scan table entries up to the fit, on a split move entries to open a slot
// and write the new entry, then write the allocated one. A miss ends at the last entry.
// Free: scan entries, fetch the following entry when there is one, write the merged
// block, then move entries to close up merged entries when entries are removed.
// Errors caught at acceptance skip the table and go straight to the result.
// Reset: table holds one free block covering the heap; entry 0 reads as that
// block until first written, so no clearing pass is needed.
// Stalls: a finished result waits in the output register; a new transaction is
// taken meanwhile, and only its own result waits on out_stall_i.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_block_allocator #(
  parameter int HEAP_BYTES    = 1048576,
  parameter int GRANULE_BYTES = 16,
  parameter int HEADER_BYTES  = 24,
  parameter int MAX_BLOCKS    = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire ffba_pkg::req_t in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output ffba_pkg::rsp_t      out_data_o
);
  import ffba_pkg::*;

  // widths
  localparam int AW  = $clog2(HEAP_BYTES);           // block start / size
  localparam int CW  = ((AW > 23) ? AW : 23) + 2;    // compare and sum width
  localparam int UW  = $clog2(HEAP_BYTES + 1);       // used total
  localparam int OW  = (UW > CNT_W) ? UW : CNT_W;
  localparam int IW  = $clog2(MAX_BLOCKS);
  localparam int NW  = $clog2(MAX_BLOCKS + 1);
  localparam int TW  = REQ_W + 1;                    // request plus granule - 1
  localparam int DL  = $clog2(GRANULE_BYTES);
  localparam int DS  = TW + DL;                      // reciprocal shift

  // ceil(2^DS / granule): exact quotient for every TW-bit dividend
  localparam longint unsigned RECIP =
    ((64'd1 << DS) + 64'(GRANULE_BYTES) - 64'd1) / 64'(GRANULE_BYTES);
  localparam logic [TW:0] RECIP_C = (TW+1)'(RECIP);

  localparam logic [CW-1:0] HDR_C  = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] GRN_C  = CW'(GRANULE_BYTES);
  localparam logic [CW-1:0] HEAP_C = CW'(HEAP_BYTES);
  localparam logic [NW-1:0] MAX_C  = NW'(MAX_BLOCKS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DIV     = 4'd1;
  localparam logic [3:0] S_SCAN_RD = 4'd2;
  localparam logic [3:0] S_SCAN_CK = 4'd3;
  localparam logic [3:0] S_SH_RD   = 4'd4;
  localparam logic [3:0] S_SH_WR   = 4'd5;
  localparam logic [3:0] S_INS     = 4'd6;
  localparam logic [3:0] S_WRI     = 4'd7;
  localparam logic [3:0] S_NX_RD   = 4'd8;
  localparam logic [3:0] S_NX_CK   = 4'd9;
  localparam logic [3:0] S_MRG     = 4'd10;
  localparam logic [3:0] S_RM_RD   = 4'd11;
  localparam logic [3:0] S_RM_WR   = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;
  localparam logic [3:0] S_MUL     = 4'd14;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] size;
    logic          free;
  } entry_t;

  localparam entry_t ENT_RST = '{start: '0, size: AW'(HEAP_BYTES - HEADER_BYTES), free: 1'b1};

  // block table
  entry_t mem [MAX_BLOCKS];
  entry_t rd_q, ent, wdata;
  logic   def_q, e0_q, we;
  logic [IW-1:0] raddr, waddr;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_q <= 1'b0;
      e0_q  <= 1'b0;
    end else begin
      def_q <= (raddr == '0) && !e0_q;
      if (we && waddr == '0) begin
        e0_q <= 1'b1;
      end
    end
  end

  assign ent = def_q ? ENT_RST : rd_q;

  // sequencer state
  logic [3:0]       state_q, state_d;
  logic             op_q, op_d;
  logic [REQ_W-1:0] req_q, req_d;
  logic [AW-1:0]    hdr_q, hdr_d;
  logic [TW-1:0]    quo_q, quo_d;
  logic [NW-1:0]    idx_q, idx_d, k_q, k_d, cnt_q, cnt_d;
  logic [1:0]       rmn_q, rmn_d;
  logic [UW-1:0]    used_q, used_d;
  entry_t           cur_q, cur_d, prv_q, prv_d, nxt_q, nxt_d;
  logic             nxv_q, nxv_d, split_q, split_d;
  logic [CW-1:0]    aligned_q, aligned_d;
  status_e          st_q, st_d;
  logic [OFF_W-1:0] pay_q, pay_d;
  logic             out_valid_q;
  rsp_t             out_q;
  logic             in_acc, out_load;

  // shared datapath pieces
  logic [TW-1:0]   rnd_up;
  logic [2*TW:0]   quo_prod;
  logic [CW-1:0]   off_x, ent_sz, fsize, msum;
  logic [NW-1:0]   idx_p1;
  logic [NW:0]     k_plus_n;
  logic            pf, nf;
  logic [OW-1:0]   used_x, free_x;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign rnd_up   = TW'(req_q) + TW'(GRANULE_BYTES - 1);
  assign quo_prod = (2*TW+1)'(rnd_up) * (2*TW+1)'(RECIP_C);
  assign off_x    = CW'(in_data_i.release_offset);
  assign ent_sz   = CW'(ent.size);
  assign idx_p1   = idx_q + NW'(1);
  assign k_plus_n = (NW+1)'(k_q) + (NW+1)'(rmn_q);
  assign fsize    = split_q ? aligned_q : CW'(cur_q.size);
  assign pf       = (idx_q != '0) && prv_q.free;
  assign nf       = nxv_q && nxt_q.free;
  assign msum     = (pf ? CW'(prv_q.size) + HDR_C : '0) + CW'(cur_q.size)
                  + (nf ? HDR_C + CW'(nxt_q.size) : '0);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    req_d     = req_q;
    hdr_d     = hdr_q;
    quo_d     = quo_q;
    idx_d     = idx_q;
    k_d       = k_q;
    rmn_d     = rmn_q;
    cnt_d     = cnt_q;
    used_d    = used_q;
    cur_d     = cur_q;
    prv_d     = prv_q;
    nxt_d     = nxt_q;
    nxv_d     = nxv_q;
    split_d   = split_q;
    aligned_d = aligned_q;
    st_d      = st_q;
    pay_d     = pay_q;
    raddr     = '0;
    waddr     = '0;
    wdata     = ent;
    we        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d  = in_data_i.op;
          req_d = in_data_i.request_bytes;
          pay_d = '0;
          idx_d = '0;
          nxv_d = 1'b0;
          if (in_data_i.op == OP_ALLOC) begin
            if (in_data_i.request_bytes == '0) begin
              st_d    = ST_ZERO;
              state_d = S_DONE;
            end else begin
              state_d = S_DIV;
            end
          end else if (off_x < HDR_C || (off_x - HDR_C) >= HEAP_C) begin
            st_d    = ST_RANGE;
            state_d = S_DONE;
          end else begin
            hdr_d   = AW'(off_x - HDR_C);
            state_d = S_SCAN_RD;
          end
        end
      end
      S_DIV: begin
        // granule count, rounded up, by reciprocal multiply
        quo_d   = TW'(quo_prod >> DS);
        state_d = S_MUL;
      end
      S_MUL: begin
        aligned_d = CW'(CW'(quo_q) * GRN_C);
        state_d   = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        raddr   = idx_q[IW-1:0];
        state_d = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (op_q == OP_ALLOC) begin
          if (ent.free && ent_sz >= aligned_q) begin
            cur_d   = ent;
            split_d = (ent_sz >= aligned_q + HDR_C + GRN_C) && (cnt_q < MAX_C);
            k_d     = cnt_q;
            if (!((ent_sz >= aligned_q + HDR_C + GRN_C) && (cnt_q < MAX_C))) begin
              state_d = S_WRI;
            end else if (cnt_q == idx_p1) begin
              state_d = S_INS;
            end else begin
              state_d = S_SH_RD;
            end
          end else if (idx_p1 == cnt_q) begin
            st_d    = ST_NOFIT;
            state_d = S_DONE;
          end else begin
            prv_d   = ent;
            idx_d   = idx_p1;
            state_d = S_SCAN_RD;
          end
        end else begin
          if (ent.start == hdr_q) begin
            if (ent.free) begin
              st_d    = ST_DOUBLE;
              state_d = S_DONE;
            end else begin
              cur_d   = ent;
              state_d = (idx_p1 < cnt_q) ? S_NX_RD : S_MRG;
            end
          end else if (idx_p1 == cnt_q) begin
            st_d    = ST_NOSTART;
            state_d = S_DONE;
          end else begin
            prv_d   = ent;
            idx_d   = idx_p1;
            state_d = S_SCAN_RD;
          end
        end
      end
      S_SH_RD: begin
        raddr   = IW'(k_q - NW'(1));
        state_d = S_SH_WR;
      end
      S_SH_WR: begin
        we    = 1'b1;
        waddr = k_q[IW-1:0];
        wdata = ent;
        k_d   = k_q - NW'(1);
        state_d = ((k_q - NW'(1)) == idx_p1) ? S_INS : S_SH_RD;
      end
      S_INS: begin
        we          = 1'b1;
        waddr       = idx_p1[IW-1:0];
        wdata.start = AW'(CW'(cur_q.start) + HDR_C + aligned_q);
        wdata.size  = AW'(CW'(cur_q.size) - aligned_q - HDR_C);
        wdata.free  = 1'b1;
        cnt_d       = cnt_q + NW'(1);
        state_d     = S_WRI;
      end
      S_WRI: begin
        we          = 1'b1;
        waddr       = idx_q[IW-1:0];
        wdata.start = cur_q.start;
        wdata.size  = AW'(fsize);
        wdata.free  = 1'b0;
        used_d      = UW'(CW'(used_q) + fsize + HDR_C);
        pay_d       = OFF_W'(CW'(cur_q.start) + HDR_C);
        st_d        = ST_OK;
        state_d     = S_DONE;
      end
      S_NX_RD: begin
        raddr   = idx_p1[IW-1:0];
        state_d = S_NX_CK;
      end
      S_NX_CK: begin
        nxt_d   = ent;
        nxv_d   = 1'b1;
        state_d = S_MRG;
      end
      S_MRG: begin
        // only the neighbors can be free: the table never holds two free in a row
        we         = 1'b1;
        wdata.free = 1'b1;
        wdata.size = AW'(msum);
        used_d     = UW'(CW'(used_q) - CW'(cur_q.size) - HDR_C);
        st_d       = ST_OK;
        if (pf) begin
          waddr       = IW'(idx_q - NW'(1));
          wdata.start = prv_q.start;
          k_d         = idx_q;
          rmn_d       = nf ? 2'd2 : 2'd1;
          state_d     = S_RM_RD;
        end else begin
          waddr       = idx_q[IW-1:0];
          wdata.start = cur_q.start;
          k_d         = idx_p1;
          rmn_d       = 2'd1;
          state_d     = nf ? S_RM_RD : S_DONE;
        end
      end
      S_RM_RD: begin
        if (k_plus_n >= (NW+1)'(cnt_q)) begin
          cnt_d   = cnt_q - NW'(rmn_q);
          state_d = S_DONE;
        end else begin
          raddr   = k_plus_n[IW-1:0];
          state_d = S_RM_WR;
        end
      end
      S_RM_WR: begin
        we      = 1'b1;
        waddr   = k_q[IW-1:0];
        wdata   = ent;
        k_d     = k_q + NW'(1);
        state_d = S_RM_RD;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= NW'(1);
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      used_q  <= used_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    req_q     <= req_d;
    hdr_q     <= hdr_d;
    quo_q     <= quo_d;
    idx_q     <= idx_d;
    k_q       <= k_d;
    rmn_q     <= rmn_d;
    cur_q     <= cur_d;
    prv_q     <= prv_d;
    nxt_q     <= nxt_d;
    nxv_q     <= nxv_d;
    split_q   <= split_d;
    aligned_q <= aligned_d;
    st_q      <= st_d;
    pay_q     <= pay_d;
    if (out_load) begin
      out_q.status         <= st_q;
      out_q.payload_offset <= (st_q == ST_OK) ? pay_q : '0;
      out_q.free_bytes     <= free_x[CNT_W-1:0];
      out_q.used_bytes     <= used_x[CNT_W-1:0];
    end
  end

  assign used_x = OW'(used_q);
  assign free_x = OW'(HEAP_BYTES) - OW'(used_q);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 && cnt_q <= MAX_C)
    else $error("block count out of range");

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(used_q) <= HEAP_C)
    else $error("used total exceeds heap");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside completion");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("accepted transaction not started");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !we)
    else $error("table write while idle");

endmodule

`default_nettype wire
